// ===== src/srma_pkg.sv =====
// shared types and constants for the sample-rate moving-average block
// no dependencies; compile first
`default_nettype none

package srma_pkg;

  // field widths
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned TIME_W    = 40;
  localparam int unsigned RATE_W    = 32;
  localparam int unsigned WIN_CFG_W = 5;

  // count * 1e6 * 256 (Q24.8 scaling folded into the constant)
  localparam int unsigned SCALE_W = 28;
  localparam logic [SCALE_W-1:0] SCALED_MICRO = 28'd256_000_000;

  // shared divider geometry
  localparam int unsigned NUM_W  = COUNT_W + SCALE_W;
  localparam int unsigned DEN_W  = TIME_W;
  localparam int unsigned DCNT_W = $clog2(NUM_W + 1);

  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  // window length after reset, before clamping to the ring depth
  localparam int unsigned WIN_RESET = 16;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== src/srma_if.sv =====
// valid/ready channel interfaces: input items, result items, window config
// depends on srma_pkg
`default_nettype none

interface srma_in_if;
  logic                                valid;
  logic                                ready;
  logic        [srma_pkg::COUNT_W-1:0] smp_count;
  logic signed [srma_pkg::TIME_W-1:0]  elapsed_us;

  modport source (output valid, output smp_count, output elapsed_us, input ready);
  modport sink   (input valid, input smp_count, input elapsed_us, output ready);
endinterface

interface srma_out_if;
  logic                         valid;
  logic                         ready;
  logic [srma_pkg::RATE_W-1:0]  avg_rate;
  logic                         rejected;

  modport source (output valid, output avg_rate, output rejected, input ready);
  modport sink   (input valid, input avg_rate, input rejected, output ready);
endinterface

interface srma_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [srma_pkg::WIN_CFG_W-1:0]  window_len;

  modport source (output valid, output window_len, input ready);
  modport sink   (input valid, input window_len, output ready);
endinterface

`default_nettype wire

// ===== src/srma_div.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on srma_pkg
`default_nettype none

module srma_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srma_pkg::div_req_t req_i,
  output srma_pkg::div_rsp_t rsp_o
);
  import srma_pkg::*;

  logic [NUM_W-1:0]  dvd_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [DEN_W:0]    partial;
  logic [DEN_W:0]    diff;
  logic              fits;

  assign partial = {rem_q, dvd_q[NUM_W-1]};
  assign diff    = partial - {1'b0, den_q};
  assign fits    = partial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend register shifts out numerator bits and fills with quotient bits
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      dvd_q <= req_i.dividend;
      den_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[NUM_W-2:0], fits};
      rem_q <= fits ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

`default_nettype wire

// ===== src/srma_ring.sv =====
// rate history memory with per-entry valid bits; invalid entries read as zero
// depends on srma_pkg
`default_nettype none

module srma_ring #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  logic                        rd_en_i,
  input  logic [AddrW-1:0]            rd_addr_i,
  output logic [srma_pkg::RATE_W-1:0] rd_data_o,
  input  logic                        wr_en_i,
  input  logic [AddrW-1:0]            wr_addr_i,
  input  logic [srma_pkg::RATE_W-1:0] wr_data_i
);
  import srma_pkg::*;

  logic [RATE_W-1:0] mem_q [Depth];
  logic [Depth-1:0]  vld_q;
  logic [RATE_W-1:0] rdat_q;
  logic              rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdat_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (clear_i) begin
        vld_q <= '0;
      end else if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i] && !clear_i;
      end
    end
  end

  assign rd_data_o = rvld_q ? rdat_q : '0;

endmodule

`default_nettype wire

// ===== src/sample_rate_moving_average.sv =====
// top level of the sample-rate moving-average estimator: sequencer and datapath
// depends on srma_pkg, srma_if, srma_div, srma_ring
//
// usage
//   in_ch  : one transfer per report (smp_count, elapsed_us in microseconds)
//   out_ch : one transfer per report (avg_rate in Q24.8 Hz, rejected flag)
//   cfg_ch : writes window_len; always ready, clears the rate history at once;
//            0 or a value above MAX_WINDOW selects MAX_WINDOW
// sequencing
//   an accepted report passes S_LOAD (read the evicted rate and start the
//   shared divider), S_DIVR (rate = product / elapsed, quotient taken when
//   the divider finishes), S_UPD (history update and start of the mean pass,
//   mean = total / entries), S_DIVM and S_FIN (output load, held while
//   out_ch is full); a rejected report (zero count, non-positive interval)
//   goes from acceptance straight to S_FIN; in_ch.ready is high only while
//   idle, so a new report is accepted only after the last has left S_FIN
// reset: history empty, running total zero, window_len = min(16, MAX_WINDOW);
//   no clearing pass, the ring keeps valid bits in flops
// stalls: the result sits in an output register; a new report is accepted
//   while it waits, and its own result holds in the last step until out_ch drains
`default_nettype none

module sample_rate_moving_average #(
  parameter int unsigned MAX_WINDOW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  srma_in_if.sink       in_ch,
  srma_out_if.source    out_ch,
  srma_cfg_if.sink      cfg_ch
);
  import srma_pkg::*;

  localparam int unsigned PTR_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned WLEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned TOT_W   = RATE_W + $clog2(MAX_WINDOW);
  localparam int unsigned WIN_RST = (WIN_RESET > MAX_WINDOW) ? MAX_WINDOW : WIN_RESET;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_DIVR = 6'b000100,
    S_UPD  = 6'b001000,
    S_DIVM = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  state_e             state_q, state_d;

  // history bookkeeping
  logic [PTR_W-1:0]   write_pos_q;
  logic               ring_full_q;
  logic [TOT_W-1:0]   total_q;
  logic [WLEN_W-1:0]  window_len_q;

  // per-item working registers
  logic [NUM_W-1:0]   num_q;
  logic [DEN_W-1:0]   den_q;
  logic [RATE_W-1:0]  rate_q;
  logic [RATE_W-1:0]  res_q;
  logic               rej_q;
  logic [PTR_W-1:0]   slot_q;

  // output register
  logic               out_valid_q;
  logic [RATE_W-1:0]  out_avg_q;
  logic               out_rej_q;

  logic               in_xfer;
  logic               cfg_xfer;
  logic               reject_w;
  logic [NUM_W-1:0]   prod_w;
  logic [WLEN_W-1:0]  win_sel;
  logic [PTR_W-1:0]   slot_w;
  logic [WLEN_W:0]    nxt_w;
  logic               wrap_w;
  logic [PTR_W-1:0]   ptr_d;
  logic               full_d;
  logic [WLEN_W-1:0]  used_raw;
  logic [WLEN_W-1:0]  used_w;
  logic [TOT_W-1:0]   total_d;
  logic [RATE_W-1:0]  old_rate;
  logic [RATE_W-1:0]  rate_sat;
  logic               out_load;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign in_ch.ready  = (state_q == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_xfer     = cfg_ch.valid && cfg_ch.ready;

  // zero count or interval <= 0 is rejected up front
  assign reject_w = (in_ch.smp_count == '0) || in_ch.elapsed_us[TIME_W-1] ||
                    (in_ch.elapsed_us == '0);

  assign prod_w = NUM_W'(in_ch.smp_count) * NUM_W'(SCALED_MICRO);

  // out-of-range window requests fall back to the full ring
  assign win_sel = ((cfg_ch.window_len == '0) ||
                    (32'(cfg_ch.window_len) > MAX_WINDOW)) ?
                   WLEN_W'(MAX_WINDOW) : WLEN_W'(cfg_ch.window_len);

  // slot to overwrite, then advance and wrap at window_len
  assign slot_w   = (32'(write_pos_q) >= 32'(window_len_q)) ? '0 : write_pos_q;
  assign nxt_w    = (WLEN_W + 1)'(slot_q) + 1'b1;
  assign wrap_w   = nxt_w >= {1'b0, window_len_q};
  assign ptr_d    = wrap_w ? '0 : PTR_W'(nxt_w);
  assign full_d   = ring_full_q || wrap_w;
  assign used_raw = full_d ? window_len_q : WLEN_W'(ptr_d);
  assign used_w   = (used_raw == '0) ? WLEN_W'(1) : used_raw;

  // drop the evicted rate, add the new one
  assign total_d = total_q - TOT_W'(old_rate) + TOT_W'(rate_q);

  // rate quotient saturates at the Q24.8 maximum
  assign rate_sat = (div_rsp.quotient[NUM_W-1:RATE_W] != '0) ?
                    RATE_MAX : div_rsp.quotient[RATE_W-1:0];

  // the one divider serves the rate pass and the mean pass
  always_comb begin
    div_req.start    = (state_q == S_LOAD) || (state_q == S_UPD);
    div_req.dividend = (state_q == S_LOAD) ? num_q : NUM_W'(total_d);
    div_req.divisor  = (state_q == S_LOAD) ? den_q : DEN_W'(used_w);
  end

  srma_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  srma_ring #(
    .Depth (MAX_WINDOW),
    .AddrW (PTR_W)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (cfg_xfer),
    .rd_en_i   (state_q == S_LOAD),
    .rd_addr_i (slot_w),
    .rd_data_o (old_rate),
    .wr_en_i   (state_q == S_UPD),
    .wr_addr_i (slot_q),
    .wr_data_i (rate_q)
  );

  assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ch.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = reject_w ? S_FIN : S_LOAD;
        end
      end
      S_LOAD: begin
        state_d = S_DIVR;
      end
      S_DIVR: begin
        if (div_rsp.done) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        state_d = S_DIVM;
      end
      S_DIVM: begin
        if (div_rsp.done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state; a config write wins over the history update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      write_pos_q  <= '0;
      ring_full_q  <= 1'b0;
      total_q      <= '0;
      window_len_q <= WLEN_W'(WIN_RST);
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_xfer) begin
        window_len_q <= win_sel;
        write_pos_q  <= '0;
        ring_full_q  <= 1'b0;
        total_q      <= '0;
      end else if (state_q == S_UPD) begin
        write_pos_q <= ptr_d;
        ring_full_q <= full_d;
        total_q     <= total_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      num_q <= prod_w;
      den_q <= DEN_W'(unsigned'(in_ch.elapsed_us));
      rej_q <= reject_w;
      res_q <= '0;
    end
    if (state_q == S_LOAD) begin
      slot_q <= slot_w;
    end
    if ((state_q == S_DIVR) && div_rsp.done) begin
      rate_q <= rate_sat;
    end
    if ((state_q == S_DIVM) && div_rsp.done) begin
      res_q <= div_rsp.quotient[RATE_W-1:0];
    end
    if (out_load) begin
      out_avg_q <= res_q;
      out_rej_q <= rej_q;
    end
  end

  assign out_ch.valid    = out_valid_q;
  assign out_ch.avg_rate = out_avg_q;
  assign out_ch.rejected = out_rej_q;

  // write pointer never leaves the active window
  a_ptr_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(write_pos_q) < 32'(window_len_q))
    else $error("write pointer outside window");

  // divider finishes only while the sequencer waits for it
  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIVR) || (state_q == S_DIVM))
    else $error("divider done in unexpected state");

  // a window write leaves an empty history behind
  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_xfer |=> (write_pos_q == '0) && !ring_full_q && (total_q == '0))
    else $error("history not cleared after window write");

  // rejected results carry a zero rate
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_rej_q) |-> (out_avg_q == '0))
    else $error("rejected result with nonzero rate");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// testbench for the sample-rate moving-average estimator: directed and random
// reports, window writes between phases, results checked against a local model
// depends on srma_pkg, srma_if and the sample_rate_moving_average rtl
`default_nettype none

module tb_top;
  import srma_pkg::*;

  localparam int unsigned MAX_WINDOW = 16;
  // random reports after the directed part, and how many window phases share them
  localparam int unsigned RANDOM_REPORTS = 1430;
  localparam int unsigned PHASES = 11;

  // running model of the ring of rates, its sum and the window setting,
  // plus the queue of mean rates still owed by the block
  class rate_scoreboard;
    typedef struct {
      logic [RATE_W-1:0] avg_rate;
      logic              rejected;
    } mean_result_t;

    logic [RATE_W-1:0] rate_hist[MAX_WINDOW];
    int unsigned       next_slot;
    bit                hist_full;
    logic [63:0]       rate_sum;
    int unsigned       win_len;
    mean_result_t      expected_means[$];
    int unsigned       errors;

    function new();
      clear_history();
      win_len = (WIN_RESET > MAX_WINDOW) ? MAX_WINDOW : WIN_RESET;
      errors  = 0;
    endfunction

    function void clear_history();
      foreach (rate_hist[i]) rate_hist[i] = '0;
      next_slot = 0;
      hist_full = 1'b0;
      rate_sum  = '0;
    endfunction

    // zero or anything above the ring depth selects the full ring
    function void set_window(logic [WIN_CFG_W-1:0] value);
      if (value == 0 || value > MAX_WINDOW) win_len = MAX_WINDOW;
      else win_len = 32'(value);
      clear_history();
    endfunction

    function void note_report(logic [COUNT_W-1:0] cnt, logic signed [TIME_W-1:0] dt);
      logic [63:0]  product;
      logic [63:0]  rate;
      int unsigned  slot;
      int unsigned  used;
      mean_result_t res;
      if (cnt == 0 || dt == 0 || dt[TIME_W-1]) begin
        // rejected report: zero output, history untouched
        res.avg_rate = '0;
        res.rejected = 1'b1;
      end else begin
        product = 64'(cnt) * 64'(SCALED_MICRO);
        rate = product / {24'd0, dt};
        if (rate > 64'(RATE_MAX)) rate = 64'(RATE_MAX);
        slot = next_slot;
        if (slot >= win_len) slot = 0;
        rate_sum = rate_sum - 64'(rate_hist[slot]) + rate;
        rate_hist[slot] = rate[RATE_W-1:0];
        slot++;
        if (slot >= win_len) begin
          slot = 0;
          hist_full = 1'b1;
        end
        next_slot = slot;
        used = hist_full ? win_len : next_slot;
        if (used == 0) used = 1;
        res.avg_rate = RATE_W'(rate_sum / used);
        res.rejected = 1'b0;
      end
      expected_means.push_back(res);
    endfunction

    function void check_result(logic [RATE_W-1:0] avg, logic rej);
      mean_result_t res;
      if (expected_means.size() == 0) begin
        $display("%0t: unexpected result: avg_rate %h rejected %b", $time, avg, rej);
        errors++;
        return;
      end
      res = expected_means.pop_front();
      if (avg !== res.avg_rate) begin
        $display("%0t: avg_rate mismatch: expected %h actual %h", $time, res.avg_rate, avg);
        errors++;
      end
      if (rej !== res.rejected) begin
        $display("%0t: rejected mismatch: expected %b actual %b", $time, res.rejected, rej);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_means.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  srma_in_if  in_ch ();
  srma_out_if out_ch ();
  srma_cfg_if cfg_ch ();

  sample_rate_moving_average #(
    .MAX_WINDOW(MAX_WINDOW)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  rate_scoreboard sb = new();

  // quiet turns off idling on both sides for the last phase
  bit          quiet = 1'b0;
  // chance in percent that a report is preceded by a gap; set per phase
  int unsigned send_gap_pct = 20;

  // every result transfer goes to the scoreboard; values sampled before the
  // edge updates, like the block itself sees them
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.avg_rate, out_ch.rejected);
    end
  end

  // result-side back-pressure: a stall chance chosen anew after each random span
  // (none, light, heavy); a stall holds out_ch.ready low for a random burst
  initial begin
    int unsigned stall_pct;
    int unsigned span;
    stall_pct = 0;
    span = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (span == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 4;
          default: stall_pct = 25;
        endcase
        span = $urandom_range(100, 400);
      end else begin
        span--;
      end
      if (!quiet && $urandom_range(1, 100) <= stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // one report transfer; returns at the edge that accepted it, with valid still
  // high so the next report can follow without a bubble
  task automatic send_report(logic [COUNT_W-1:0] cnt, logic signed [TIME_W-1:0] dt);
    if (!quiet && $urandom_range(1, 100) <= send_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.smp_count  <= cnt;
    in_ch.elapsed_us <= dt;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_report(cnt, dt);
  endtask

  // drop valid, then the block goes idle once every owed result has been seen
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // window write; only issued with the block idle and in_ch quiet
  task automatic write_window(logic [WIN_CFG_W-1:0] value);
    in_ch.valid       <= 1'b0;
    cfg_ch.valid      <= 1'b1;
    cfg_ch.window_len <= value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    sb.set_window(value);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // random report: mostly well-formed with rates spread over the whole range,
  // some zero counts and non-positive intervals mixed in
  task automatic send_random_report();
    logic [COUNT_W-1:0]       cnt;
    logic signed [TIME_W-1:0] dt;
    int unsigned              pick;
    int unsigned              w;
    pick = $urandom_range(0, 99);
    // count: full range, tiny, or a random bit width
    case ($urandom_range(0, 2))
      0: cnt = COUNT_W'($urandom_range(1, 65535));
      1: cnt = COUNT_W'($urandom_range(1, 15));
      default: begin
        w = $urandom_range(1, COUNT_W);
        cnt = COUNT_W'($urandom) & COUNT_W'((32'd1 << w) - 1);
        if (cnt == 0) cnt = COUNT_W'(1);
      end
    endcase
    // interval: positive with a random bit width, so rates from saturated to zero
    w = $urandom_range(1, TIME_W - 1);
    dt = TIME_W'({$urandom, $urandom}) & TIME_W'((64'd1 << w) - 1);
    if (dt == 0) dt = TIME_W'(1);
    if (pick < 6) begin
      cnt = '0;
      if ($urandom_range(0, 1) == 1) dt = TIME_W'({$urandom, $urandom});
    end else if (pick < 12) begin
      // zero or negative interval
      if ($urandom_range(0, 3) == 0) dt = '0;
      else dt = {1'b1, (TIME_W-1)'({$urandom, $urandom})};
    end
    send_report(cnt, dt);
  endtask

  initial begin
    logic [WIN_CFG_W-1:0] phase_win[7];
    int unsigned          per_phase;
    int unsigned          p;
    phase_win = '{5'd1, 5'd2, 5'd0, 5'd31, 5'd16, 5'd17, 5'd5};
    per_phase = RANDOM_REPORTS / PHASES;

    rst_ni            <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.smp_count   <= '0;
    in_ch.elapsed_us  <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.window_len <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, reset window of 16
    // rejections: zero count, zero interval, negative intervals, both at once
    send_report(16'd0, 40'sd1000);
    send_report(16'd100, 40'sd0);
    send_report(16'd100, -40'sd1);
    send_report(16'hFFFF, {1'b1, 39'd0});
    send_report(16'd0, 40'sd0);
    // saturation edge: 65535 * 256e6 / 3906 overflows Q24.8, / 3907 does not
    send_report(16'd1, 40'sd1);
    send_report(16'hFFFF, 40'sd1);
    send_report(16'hFFFF, 40'sd3906);
    send_report(16'hFFFF, 40'sd3907);
    // longest interval: rates collapse toward zero
    send_report(16'd1, {1'b0, {39{1'b1}}});
    send_report(16'hFFFF, {1'b0, {39{1'b1}}});
    // one lsb of rate and just under it
    send_report(16'd1, 40'sd256000000);
    send_report(16'd1, 40'sd256000001);
    send_report(16'd1000, 40'sd1000000);
    send_report(16'd32768, 40'sd12345);
    send_report(16'h5555, 40'sh55_5555_5555);
    send_report(16'hAAAA, 40'sh2A_AAAA_AAAA);
    // rejected report after some history must not disturb the mean
    send_report(16'h00FF, -40'sd12345);
    send_report(16'd7, 40'sd1);
    send_report(16'd48000, 40'sd1000000);

    // random phases, each behind a window write; fixed windows first, including
    // the extremes and the out-of-range values, then random ones
    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      if (p < 7) write_window(phase_win[p]);
      else write_window(WIN_CFG_W'($urandom_range(0, 31)));
      case ($urandom_range(0, 2))
        0: send_gap_pct = 0;
        1: send_gap_pct = 10;
        default: send_gap_pct = 50;
      endcase
      // last phase runs with no idling on either side
      if (p == PHASES - 1) quiet = 1'b1;
      repeat (per_phase) send_random_report();
    end

    wait_drained();
    // room for anything stray beyond one result latency
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

`default_nettype wire
